>>> rtl/assert_macros.svh
// Assertion helpers for the caption framer checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, ignored while in reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("framer check failed");

// Implication in the next cycle, ignored while in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("framer check failed");

// Implication in the next cycle, checked through reset as well.
`define ASSERT_NEXT_NR(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("framer check failed");

`endif

>>> rtl/ccsf_pkg.sv
// ---------------------------------------------------------------------------
// ccsf_pkg
// Types, stream constants and header table for the caption SEI framer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ccsf_pkg;

  // One caption item as presented on the input side.
  typedef struct packed {
    logic       first_of_packet;
    logic       last_of_packet;
    logic       has_entry;
    logic [4:0] entry_count;
    logic       entry_valid;
    logic [1:0] entry_type;
    logic [7:0] entry_byte_a;
    logic [7:0] entry_byte_b;
  } item_t;

  // One output byte of the SEI stream.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_packet;
  } result_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    logic       first;
    logic       last;
    logic       has;
    logic [4:0] count;
    logic [7:0] tag;
    logic [7:0] byte_a;
    logic [7:0] byte_b;
  } cmd_t;

  // Command queue depth.
  localparam int QDepth = 2;
  localparam int QAw    = $clog2(QDepth);
  localparam int QCw    = $clog2(QDepth + 1);

  // Byte position within one command's output run.
  typedef logic [4:0] phase_t;
  localparam phase_t PH_HDR0  = 5'd0;
  localparam phase_t PH_FLAGS = 5'd15;
  localparam phase_t PH_EM    = 5'd16;
  localparam phase_t PH_CC0   = 5'd17;
  localparam phase_t PH_CC1   = 5'd18;
  localparam phase_t PH_CC2   = 5'd19;
  localparam phase_t PH_MARK  = 5'd20;

  localparam logic [7:0] CC_TAG_BASE = 8'hf8;
  localparam logic [7:0] FLAGS_BASE  = 8'hc0;
  localparam logic [7:0] MARK_BYTE   = 8'hff;

  // Fixed header: start code, NAL header, SEI type, T.35 codes, GA94, type 3.
  function automatic logic [7:0] hdr_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h00;
      4'd1:    b = 8'h00;
      4'd2:    b = 8'h01;
      4'd3:    b = 8'h4e;
      4'd4:    b = 8'h01;
      4'd5:    b = 8'h04;
      4'd6:    b = 8'h47;
      4'd7:    b = 8'hb5;
      4'd8:    b = 8'h00;
      4'd9:    b = 8'h31;
      4'd10:   b = 8'h47;
      4'd11:   b = 8'h41;
      4'd12:   b = 8'h39;
      4'd13:   b = 8'h34;
      4'd14:   b = 8'h03;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/cea708_caption_sei_framer.sv
// ---------------------------------------------------------------------------
// cea708_caption_sei_framer
// Frames caption triples into an HEVC prefix SEI carrying ATSC GA94 cc_data.
// ---------------------------------------------------------------------------
// One result byte leaves per clock while the consumer keeps popping. An item
// carrying only a caption triple yields 3 bytes, a first item adds 17 header
// bytes and a last item one marker byte, so an item yields 1 to 21 bytes. A
// two-entry command queue lets new items in while earlier ones are still being
// framed. Items with neither mark nor entry are accepted and produce nothing.
`timescale 1ns / 1ps

module cea708_caption_sei_framer (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  ccsf_pkg::item_t   item,
  output logic              empty,
  input  logic              pop,
  output ccsf_pkg::result_t result
);

  logic           q_wr;
  logic           q_full;
  logic           q_valid;
  logic           q_rd;
  ccsf_pkg::cmd_t wr_cmd;
  ccsf_pkg::cmd_t rd_cmd;

  ccsf_front u_front (
    .push   (push),
    .full   (full),
    .item   (item),
    .q_full (q_full),
    .q_wr   (q_wr),
    .q_cmd  (wr_cmd)
  );

  ccsf_cmd_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_cmd  (wr_cmd),
    .q_full  (q_full),
    .q_valid (q_valid),
    .rd      (q_rd),
    .rd_cmd  (rd_cmd)
  );

  ccsf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .cmd     (rd_cmd),
    .q_rd    (q_rd),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

>>> rtl/ccsf_front.sv
// ---------------------------------------------------------------------------
// ccsf_front
// Input side: accepts items, builds the cc tag byte, drops items with no work.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccsf_front (
  input  logic          push,
  output logic          full,
  input  ccsf_pkg::item_t item,
  input  logic          q_full,
  output logic          q_wr,
  output ccsf_pkg::cmd_t q_cmd
);

  logic has_work;

  assign full     = q_full;
  assign has_work = item.first_of_packet | item.last_of_packet | item.has_entry;

  // Drop items that frame nothing.
  assign q_wr = push & ~q_full & has_work;

  always_comb begin
    q_cmd.first  = item.first_of_packet;
    q_cmd.last   = item.last_of_packet;
    q_cmd.has    = item.has_entry;
    q_cmd.count  = item.entry_count;
    q_cmd.tag    = ccsf_pkg::CC_TAG_BASE | {5'd0, item.entry_valid, item.entry_type};
    q_cmd.byte_a = item.entry_byte_a;
    q_cmd.byte_b = item.entry_byte_b;
  end

endmodule

>>> rtl/ccsf_cmd_fifo.sv
// ---------------------------------------------------------------------------
// ccsf_cmd_fifo
// Short command queue between front and back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccsf_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  ccsf_pkg::cmd_t wr_cmd,
  output logic           q_full,
  output logic           q_valid,
  input  logic           rd,
  output ccsf_pkg::cmd_t rd_cmd
);

  ccsf_pkg::cmd_t                   entries [ccsf_pkg::QDepth];
  logic [ccsf_pkg::QAw-1:0]         wr_ptr;
  logic [ccsf_pkg::QAw-1:0]         rd_ptr;
  logic [ccsf_pkg::QCw-1:0]         count;
  logic                             do_rd;

  assign q_full  = (count == ccsf_pkg::QCw'(ccsf_pkg::QDepth));
  assign q_valid = (count != '0);
  assign rd_cmd  = entries[rd_ptr];
  assign do_rd   = rd & q_valid;

  always_ff @(posedge clk) begin
    if (wr) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == ccsf_pkg::QAw'(ccsf_pkg::QDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == ccsf_pkg::QAw'(ccsf_pkg::QDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (!wr && do_rd) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/ccsf_back.sv
// ---------------------------------------------------------------------------
// ccsf_back
// Byte sequencer: walks each command through header, entry and marker bytes
// into a one-entry output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccsf_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  ccsf_pkg::cmd_t   cmd,
  output logic             q_rd,
  output logic             empty,
  input  logic             pop,
  output ccsf_pkg::result_t result
);

  logic              busy;
  logic              busy_next;
  ccsf_pkg::phase_t  phase;
  ccsf_pkg::phase_t  phase_next;
  ccsf_pkg::phase_t  cur;
  ccsf_pkg::phase_t  start;
  logic              out_valid;
  logic              out_free;
  logic              emit;
  logic              done;
  logic              has_work;
  ccsf_pkg::result_t byte_r;

  assign out_free = ~out_valid | pop;
  assign empty    = ~out_valid;
  assign has_work = cmd.first | cmd.has | cmd.last;

  always_comb begin
    if (cmd.first) begin
      start = ccsf_pkg::PH_HDR0;
    end else if (cmd.has) begin
      start = ccsf_pkg::PH_CC0;
    end else begin
      start = ccsf_pkg::PH_MARK;
    end
  end

  assign cur  = busy ? phase : start;
  assign emit = q_valid & has_work & out_free;

  // Pick the byte and the step after it.
  always_comb begin
    byte_r.end_of_packet = 1'b0;
    done                 = 1'b0;
    phase_next           = cur + 1'b1;
    if (cur < ccsf_pkg::PH_FLAGS) begin
      byte_r.out_byte = ccsf_pkg::hdr_byte(cur[3:0]);
    end else begin
      unique case (cur)
        ccsf_pkg::PH_FLAGS: byte_r.out_byte = ccsf_pkg::FLAGS_BASE | {3'd0, cmd.count};
        ccsf_pkg::PH_EM: begin
          byte_r.out_byte = ccsf_pkg::MARK_BYTE;
          if (cmd.has) begin
            phase_next = ccsf_pkg::PH_CC0;
          end else if (cmd.last) begin
            phase_next = ccsf_pkg::PH_MARK;
          end else begin
            done = 1'b1;
          end
        end
        ccsf_pkg::PH_CC0: byte_r.out_byte = cmd.tag;
        ccsf_pkg::PH_CC1: byte_r.out_byte = cmd.byte_a;
        ccsf_pkg::PH_CC2: begin
          byte_r.out_byte = cmd.byte_b;
          if (cmd.last) begin
            phase_next = ccsf_pkg::PH_MARK;
          end else begin
            done = 1'b1;
          end
        end
        default: begin
          byte_r.out_byte      = ccsf_pkg::MARK_BYTE;
          byte_r.end_of_packet = 1'b1;
          done                 = 1'b1;
        end
      endcase
    end
  end

  // Retire a command on its last byte; drop one with nothing to send.
  assign q_rd = q_valid & ((emit & done) | ~has_work);

  always_comb begin
    busy_next = busy;
    if (emit) begin
      busy_next = ~done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      busy <= busy_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      phase  <= phase_next;
      result <= byte_r;
    end
  end

endmodule

>>> rtl/ccsf_checker.sv
// ---------------------------------------------------------------------------
// ccsf_checker
// Port-level checks for the caption SEI framer, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ccsf_checker (
  input logic              clk,
  input logic              rst,
  input logic              push,
  input logic              full,
  input ccsf_pkg::item_t   item,
  input logic              empty,
  input logic              pop,
  input ccsf_pkg::result_t result
);

  logic item_has_work;

  assign item_has_work = item.first_of_packet | item.last_of_packet | item.has_entry;

  `ASSERT_NEXT_NR(a_reset_clear, clk, rst, empty && !full)
  `ASSERT_NEXT(a_result_hold, clk, rst, !empty && !pop, !empty && $stable(result))
  `ASSERT_IMPL(a_marker_byte, clk, rst, !empty && result.end_of_packet, result.out_byte == 8'hff)
  `ASSERT_NEXT(a_work_shows, clk, rst, push && !full && item_has_work, ##1 !empty)

endmodule

bind cea708_caption_sei_framer ccsf_checker u_ccsf_checker (
  .clk    (clk),
  .rst    (rst),
  .push   (push),
  .full   (full),
  .item   (item),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

>>> sim/tb_cea708_caption_sei_framer.sv
// ---------------------------------------------------------------------------
// tb_cea708_caption_sei_framer
// Self-checking bench for the caption SEI framer: caption items go in through
// the push side, and every stream byte popped is compared with a byte-level
// prediction of the GA94 SEI framing. Directed packets come first, then random
// packet traffic under four flow-control mixes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_cea708_caption_sei_framer;

  localparam int WatchdogLimit = 4000;
  // One item can hold the sequencer for 21 output bytes and one more can wait in
  // its command queue.
  localparam int SettleCycles  = 80;
  localparam int MaxReports    = 10;

  // Start code, NAL header, SEI type, T.35 codes, "GA94", user data type 3.
  localparam logic [7:0] SeiHeader [0:14] = '{
    8'h00, 8'h00, 8'h01, 8'h4e, 8'h01, 8'h04, 8'h47, 8'hb5,
    8'h00, 8'h31, 8'h47, 8'h41, 8'h39, 8'h34, 8'h03
  };
  localparam logic [7:0] FlagsMark = 8'hc0;
  localparam logic [7:0] CcTagMark = 8'hf8;
  localparam logic [7:0] FillByte  = 8'hff;

  logic              clk  = 1'b0;
  logic              rst  = 1'b1;
  logic              push = 1'b0;
  logic              full;
  ccsf_pkg::item_t   item = '0;
  logic              empty;
  logic              pop  = 1'b0;
  ccsf_pkg::result_t result;

  ccsf_pkg::result_t stream_bytes_due[$];
  int      send_idle_pct = 0;
  int      pop_stall_pct = 0;
  int      items_sent    = 0;
  int      packets_sent  = 0;
  int      bytes_checked = 0;
  int      mismatches    = 0;
  int      quiet_cycles  = 0;

  always #5 clk = ~clk;

  cea708_caption_sei_framer i_dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  function automatic void due_byte(input logic [7:0] b, input logic eop);
    ccsf_pkg::result_t r;
    r.out_byte      = b;
    r.end_of_packet = eop;
    stream_bytes_due.push_back(r);
  endfunction

  // Append the stream bytes that one caption item produces.
  function automatic void frame_caption_item(input ccsf_pkg::item_t it);
    if (it.first_of_packet) begin
      for (int i = 0; i < 15; i++) due_byte(SeiHeader[i], 1'b0);
      due_byte(FlagsMark | {3'b000, it.entry_count}, 1'b0);
      due_byte(FillByte, 1'b0);
    end
    if (it.has_entry) begin
      due_byte(CcTagMark | {5'b00000, it.entry_valid, it.entry_type}, 1'b0);
      due_byte(it.entry_byte_a, 1'b0);
      due_byte(it.entry_byte_b, 1'b0);
    end
    if (it.last_of_packet) due_byte(FillByte, 1'b1);
  endfunction

  task automatic report_mismatch(input string what, input ccsf_pkg::result_t want,
                                 input ccsf_pkg::result_t got);
    mismatches++;
    if (mismatches <= MaxReports)
      $display("%0t: %s: expected byte %02h eop %0b, got byte %02h eop %0b",
               $realtime, what, want.out_byte, want.end_of_packet,
               got.out_byte, got.end_of_packet);
  endtask

  // Monitor both handshakes at the rising edge; results are checked before
  // new items are framed since no byte can leave in its item's own cycle.
  always @(posedge clk) begin : monitor_p
    ccsf_pkg::result_t want;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (pop && !empty) begin
        bytes_checked++;
        if (stream_bytes_due.size() == 0) begin
          report_mismatch("byte with none pending", '0, result);
        end else begin
          want = stream_bytes_due.pop_front();
          if (result.out_byte !== want.out_byte ||
              result.end_of_packet !== want.end_of_packet)
            report_mismatch("stream byte mismatch", want, result);
        end
      end
      if (push && !full) frame_caption_item(item);
      if ((pop && !empty) || (push && !full)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: no handshake for %0d cycles", $realtime, WatchdogLimit);
        $display("tb_cea708_caption_sei_framer: FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  always @(negedge clk) begin
    pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  // Present one item at the falling edge and hold it until accepted. Push
  // stays high on return; the next send or a drain decides what follows.
  task automatic send_item(input ccsf_pkg::item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    item = it;
    do @(posedge clk); while (full);
    if (it.first_of_packet || it.last_of_packet || it.has_entry) items_sent++;
  endtask

  // Hold off the sender until every pending byte has come out.
  task automatic wait_drained();
    @(negedge clk);
    push = 1'b0;
    while (stream_bytes_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic ccsf_pkg::item_t caption_item(input logic first, input logic last,
                                                   input logic has,
                                                   input logic [4:0] count);
    ccsf_pkg::item_t it;
    it                 = ccsf_pkg::item_t'($urandom);
    it.first_of_packet = first;
    it.last_of_packet  = last;
    it.has_entry       = has;
    it.entry_count     = count;
    return it;
  endfunction

  task automatic send_packet(input int n_entries, input logic [4:0] count);
    packets_sent++;
    if (n_entries == 0) begin
      send_item(caption_item(1'b1, 1'b1, 1'b0, count));
    end else begin
      for (int i = 0; i < n_entries; i++)
        send_item(caption_item(i == 0, i == n_entries - 1, 1'b1, count));
    end
  endtask

  task automatic test_empty_packet();
    send_item('{1'b1, 1'b1, 1'b0, 5'd0, 1'b0, 2'd0, 8'h00, 8'h00});
    send_item('{1'b1, 1'b1, 1'b0, 5'd31, 1'b1, 2'd3, 8'hff, 8'hff});
    packets_sent += 2;
    wait_drained();
  endtask

  // Every valid/type pair, with data bytes at both extremes.
  task automatic test_entry_fields();
    ccsf_pkg::item_t it;
    for (int i = 0; i < 8; i++) begin
      it = '{i == 0, i == 7, 1'b1, 5'd8, i[2], i[1:0],
             i[0] ? 8'hff : 8'h00, i[0] ? 8'h00 : 8'hff};
      send_item(it);
    end
    packets_sent++;
    wait_drained();
  endtask

  task automatic test_single_item_packet();
    send_item('{1'b1, 1'b1, 1'b1, 5'd1, 1'b1, 2'd3, 8'hff, 8'hff});
    send_item('{1'b1, 1'b1, 1'b1, 5'd1, 1'b0, 2'd0, 8'h00, 8'h00});
    packets_sent += 2;
    wait_drained();
  endtask

  task automatic test_missing_marks();
    send_item(caption_item(1'b0, 1'b0, 1'b0, 5'd31));  // framer drops it
    send_item(caption_item(1'b0, 1'b0, 1'b1, 5'd0));   // entry, no header
    send_item(caption_item(1'b0, 1'b1, 1'b0, 5'd0));   // marker alone
    send_item(caption_item(1'b1, 1'b0, 1'b0, 5'd31));  // header alone
    send_item(caption_item(1'b0, 1'b1, 1'b1, 5'd5));   // entry and marker
    wait_drained();
  endtask

  task automatic test_count_mismatch();
    send_packet(2, 5'd31);
    send_packet(1, 5'd0);
    wait_drained();
  endtask

  task automatic test_random_packets(input int n_items, input int idle_pct,
                                     input int stall_pct);
    int              target;
    int              roll;
    int              n;
    logic [4:0]      count;
    ccsf_pkg::item_t raw;
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    target        = items_sent + n_items;
    while (items_sent < target) begin
      roll = $urandom_range(99);
      if (roll < 80) begin
        n     = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(4);
        count = ($urandom_range(7) == 0) ? 5'($urandom) : 5'(n);
        send_packet(n, count);
      end else if (roll < 92) begin
        // stray or broken framing
        send_item(caption_item(1'($urandom), 1'($urandom), 1'($urandom),
                               5'($urandom)));
      end else begin
        raw = ccsf_pkg::item_t'($urandom);
        send_item(raw);
      end
      if ($urandom_range(24) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst = 1'b0;

    test_empty_packet();
    test_entry_fields();
    test_single_item_packet();
    test_missing_marks();
    test_count_mismatch();
    test_random_packets(85, 0, 0);
    test_random_packets(85, 65, 0);
    test_random_packets(85, 0, 65);
    test_random_packets(85, 34, 34);

    if (stream_bytes_due.size() != 0) begin
      $display("%0d stream bytes never arrived", stream_bytes_due.size());
      mismatches += stream_bytes_due.size();
    end
    $display("Sent %0d caption items in about %0d packets; checked %0d stream bytes.",
             items_sent, packets_sent, bytes_checked);
    $display("Covered empty, single-item, header-only and unframed packets under four stall mixes.");
    if (mismatches == 0) begin
      $display("tb_cea708_caption_sei_framer: PASS");
    end else begin
      $display("tb_cea708_caption_sei_framer: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/ccsf_pkg.sv
rtl/ccsf_front.sv
rtl/ccsf_cmd_fifo.sv
rtl/ccsf_back.sv
rtl/cea708_caption_sei_framer.sv
rtl/ccsf_checker.sv
sim/tb_cea708_caption_sei_framer.sv
